// ----- rtl/rwsc_pkg.sv -----
// Package for the rain wiper speed controller.
// Holds the channel payload types, event and register codes, and the window
// averaging constants. It depends on nothing else.
package rwsc_pkg;

  // Number of rain samples in one averaging window (1 to 15).
  localparam int WINDOW_SAMPLES = 10;

  // Averages use a reciprocal multiply: floor(sum * RECIP >> RECIP_SHIFT).
  // With a 16-bit sum and a window of at most 15 this is exact.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);

  localparam int SUM_W  = 16;
  localparam int ADC_W  = 12;
  localparam int IDX_W  = 4;
  localparam int TIME_W = 32;
  localparam int MS_W   = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Event codes carried in the func field.
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SPEED  = 2'd1;
  localparam logic [1:0] FUNC_MODE   = 2'd2;
  localparam logic [1:0] FUNC_SAMPLE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_OFF      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_LOW      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_MODERATE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_HEAVY     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_MEDIUM    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_LIGHT     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT       = 8'd7;

  // Wiper speed codes.
  localparam logic [1:0] SPEED_OFF      = 2'd0;
  localparam logic [1:0] SPEED_LOW      = 2'd1;
  localparam logic [1:0] SPEED_MODERATE = 2'd2;
  localparam logic [1:0] SPEED_HIGH     = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [ADC_W-1:0] vib_sample;
    logic [ADC_W-1:0] ir_sample;
    logic             rain_present;
  } in_t;

  typedef struct packed {
    logic [1:0]       speed;
    logic             auto_on;
    logic             rain_led;
    logic [ADC_W-1:0] avg_vibration;
    logic [ADC_W-1:0] avg_ir;
    logic             decided;
    logic             report_due;
  } out_t;

  // Thresholds used by the speed decision.
  typedef struct packed {
    logic [ADC_W-1:0] vib_off;
    logic [ADC_W-1:0] vib_low;
    logic [ADC_W-1:0] vib_moderate;
    logic [ADC_W-1:0] ir_heavy;
    logic [ADC_W-1:0] ir_medium;
    logic [ADC_W-1:0] ir_light;
  } levels_t;

  // Result of one completed window.
  typedef struct packed {
    logic [ADC_W-1:0] vib_avg;
    logic [ADC_W-1:0] ir_avg;
    logic [1:0]       speed;
  } decision_t;

endpackage

// ----- rtl/rain_wiper_speed_controller.sv -----
// Top level of the rain wiper speed controller: event handling, state,
// configuration registers and a two-entry output buffer.
// Depends on rwsc_pkg and rwsc_decide.
//
//   channel   handshake            payload
//   in_       in_valid / in_stall  in_data (rwsc_pkg::in_t)
//   out_      out_valid/ out_stall out_data (rwsc_pkg::out_t)
//   cfg_      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Every event is handled in the cycle it is accepted; its result is
// registered in out_r, or as a second result in skid_r while out_stall is
// high, so one event per cycle is sustained while skid_r is empty. The rate
// is set by the single pass of window sum, reciprocal multiply and threshold
// compares; in_stall rises only when out_r and skid_r are both full.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
module rain_wiper_speed_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rwsc_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rwsc_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwsc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = rwsc_pkg::TIME_W;

  // Configuration registers.
  rwsc_pkg::levels_t               levels_r;
  logic [rwsc_pkg::MS_W-1:0]       debounce_r;
  logic [rwsc_pkg::MS_W-1:0]       report_r;

  // Controller state.
  logic [TW-1:0]                   ms_r, ms_nxt;
  logic [TW-1:0]                   speed_last_r, speed_last_nxt;
  logic [TW-1:0]                   mode_last_r, mode_last_nxt;
  logic [TW-1:0]                   report_last_r, report_last_nxt;
  logic [1:0]                      speed_r, speed_nxt;
  logic                            auto_r, auto_nxt;
  logic                            lamp_r, lamp_nxt;
  logic [rwsc_pkg::SUM_W-1:0]      vib_sum_r, vib_sum_nxt;
  logic [rwsc_pkg::SUM_W-1:0]      ir_sum_r, ir_sum_nxt;
  logic [rwsc_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [rwsc_pkg::ADC_W-1:0]      vib_hold_r, vib_hold_nxt;
  logic [rwsc_pkg::ADC_W-1:0]      ir_hold_r, ir_hold_nxt;

  // Output buffer.
  rwsc_pkg::out_t                  out_r;
  rwsc_pkg::out_t                  skid_r;
  logic                            out_valid_r;
  logic                            skid_valid_r;

  logic                            in_accept;
  logic                            out_fire;
  logic [rwsc_pkg::SUM_W-1:0]      vib_add;
  logic [rwsc_pkg::SUM_W-1:0]      ir_add;
  logic [rwsc_pkg::IDX_W-1:0]      idx_add;
  logic [TW-1:0]                   tick_ms;
  logic                            decided;
  logic                            report;
  rwsc_pkg::decision_t             decision;
  rwsc_pkg::out_t                  result;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_fire  = out_valid_r && !out_stall;

  // Running sums including the current sample, and the window decision.
  assign vib_add = vib_sum_r + rwsc_pkg::SUM_W'(in_data.vib_sample);
  assign ir_add  = ir_sum_r + rwsc_pkg::SUM_W'(in_data.ir_sample);
  assign idx_add = idx_r + rwsc_pkg::IDX_W'(1);
  assign tick_ms = ms_r + TW'(1);

  rwsc_decide u_decide (
    .vib_sum  (vib_add),
    .ir_sum   (ir_add),
    .levels   (levels_r),
    .decision (decision)
  );

  // Next state for the event at the input.
  always_comb begin
    ms_nxt          = ms_r;
    speed_last_nxt  = speed_last_r;
    mode_last_nxt   = mode_last_r;
    report_last_nxt = report_last_r;
    speed_nxt       = speed_r;
    auto_nxt        = auto_r;
    lamp_nxt        = lamp_r;
    vib_sum_nxt     = vib_sum_r;
    ir_sum_nxt      = ir_sum_r;
    idx_nxt         = idx_r;
    vib_hold_nxt    = vib_hold_r;
    ir_hold_nxt     = ir_hold_r;
    decided         = 1'b0;
    report          = 1'b0;

    unique case (in_data.func)
      rwsc_pkg::FUNC_TICK: begin
        ms_nxt = tick_ms;
        if ((tick_ms - report_last_r) >= TW'(report_r)) begin
          report_last_nxt = tick_ms;
          report          = 1'b1;
        end
      end
      rwsc_pkg::FUNC_SPEED: begin
        if ((ms_r - speed_last_r) > TW'(debounce_r)) begin
          speed_last_nxt = ms_r;
          if (!auto_r) begin
            speed_nxt = speed_r + 2'd1;
          end
        end
      end
      rwsc_pkg::FUNC_MODE: begin
        if ((ms_r - mode_last_r) > TW'(debounce_r)) begin
          mode_last_nxt = ms_r;
          auto_nxt      = !auto_r;
          if (auto_r) begin
            speed_nxt = rwsc_pkg::SPEED_OFF;
          end
          vib_sum_nxt = '0;
          ir_sum_nxt  = '0;
          idx_nxt     = '0;
        end
      end
      rwsc_pkg::FUNC_SAMPLE: begin
        if (auto_r) begin
          if (in_data.rain_present) begin
            if (idx_add >= rwsc_pkg::IDX_W'(rwsc_pkg::WINDOW_SAMPLES)) begin
              vib_hold_nxt = decision.vib_avg;
              ir_hold_nxt  = decision.ir_avg;
              speed_nxt    = decision.speed;
              lamp_nxt     = 1'b1;
              decided      = 1'b1;
              vib_sum_nxt  = '0;
              ir_sum_nxt   = '0;
              idx_nxt      = '0;
            end else begin
              vib_sum_nxt = vib_add;
              ir_sum_nxt  = ir_add;
              idx_nxt     = idx_add;
            end
          end else begin
            speed_nxt   = rwsc_pkg::SPEED_OFF;
            lamp_nxt    = 1'b0;
            vib_sum_nxt = '0;
            ir_sum_nxt  = '0;
            idx_nxt     = '0;
          end
        end
      end
      default: begin
      end
    endcase

    result.speed         = speed_nxt;
    result.auto_on       = auto_nxt;
    result.rain_led      = lamp_nxt;
    result.avg_vibration = vib_hold_nxt;
    result.avg_ir        = ir_hold_nxt;
    result.decided       = decided;
    result.report_due    = report;
  end

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r          <= '0;
      speed_last_r  <= '0;
      mode_last_r   <= '0;
      report_last_r <= '0;
      speed_r       <= rwsc_pkg::SPEED_OFF;
      auto_r        <= 1'b0;
      lamp_r        <= 1'b0;
      vib_sum_r     <= '0;
      ir_sum_r      <= '0;
      idx_r         <= '0;
      vib_hold_r    <= '0;
      ir_hold_r     <= '0;
    end else if (in_accept) begin
      ms_r          <= ms_nxt;
      speed_last_r  <= speed_last_nxt;
      mode_last_r   <= mode_last_nxt;
      report_last_r <= report_last_nxt;
      speed_r       <= speed_nxt;
      auto_r        <= auto_nxt;
      lamp_r        <= lamp_nxt;
      vib_sum_r     <= vib_sum_nxt;
      ir_sum_r      <= ir_sum_nxt;
      idx_r         <= idx_nxt;
      vib_hold_r    <= vib_hold_nxt;
      ir_hold_r     <= ir_hold_nxt;
    end
  end

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r.vib_off      <= 12'd50;
      levels_r.vib_low      <= 12'd500;
      levels_r.vib_moderate <= 12'd1000;
      levels_r.ir_heavy     <= 12'd50;
      levels_r.ir_medium    <= 12'd85;
      levels_r.ir_light     <= 12'd120;
      debounce_r            <= 16'd200;
      report_r              <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rwsc_pkg::CFG_VIB_OFF:      levels_r.vib_off      <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_VIB_LOW:      levels_r.vib_low      <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_VIB_MODERATE: levels_r.vib_moderate <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_IR_HEAVY:     levels_r.ir_heavy     <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_IR_MEDIUM:    levels_r.ir_medium    <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_IR_LIGHT:     levels_r.ir_light     <= cfg_data[rwsc_pkg::ADC_W-1:0];
        rwsc_pkg::CFG_DEBOUNCE:     debounce_r            <= cfg_data;
        rwsc_pkg::CFG_REPORT:       report_r              <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r && out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else if (in_accept) begin
        if (!out_valid_r || !out_stall) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r && out_fire) begin
      out_r <= skid_r;
    end else if (in_accept) begin
      if (!out_valid_r || !out_stall) begin
        out_r <= result;
      end else begin
        skid_r <= result;
      end
    end
  end

endmodule

// ----- rtl/rwsc_decide.sv -----
// Window decision logic: floor averages of the two sums and the speed pick.
// Depends on rwsc_pkg for the level and decision types and the reciprocal.
module rwsc_decide (
  input  logic [rwsc_pkg::SUM_W-1:0] vib_sum,
  input  logic [rwsc_pkg::SUM_W-1:0] ir_sum,
  input  rwsc_pkg::levels_t          levels,
  output rwsc_pkg::decision_t        decision
);

  localparam int PROD_W = rwsc_pkg::SUM_W + rwsc_pkg::RECIP_W;

  logic [PROD_W-1:0]             vib_prod;
  logic [PROD_W-1:0]             ir_prod;
  logic [rwsc_pkg::ADC_W-1:0]    vib_avg;
  logic [rwsc_pkg::ADC_W-1:0]    ir_avg;
  logic [1:0]                    grade;

  // Divide by the window length through a reciprocal multiply.
  assign vib_prod = PROD_W'(vib_sum) * PROD_W'(rwsc_pkg::RECIP);
  assign ir_prod  = PROD_W'(ir_sum) * PROD_W'(rwsc_pkg::RECIP);
  assign vib_avg  = vib_prod[rwsc_pkg::RECIP_SHIFT +: rwsc_pkg::ADC_W];
  assign ir_avg   = ir_prod[rwsc_pkg::RECIP_SHIFT +: rwsc_pkg::ADC_W];

  // Grade the IR average, then let vibration adjust the grade.
  always_comb begin
    if (ir_avg < levels.ir_heavy) begin
      grade = rwsc_pkg::SPEED_HIGH;
    end else if (ir_avg < levels.ir_medium) begin
      grade = rwsc_pkg::SPEED_MODERATE;
    end else if (ir_avg < levels.ir_light) begin
      grade = rwsc_pkg::SPEED_LOW;
    end else begin
      grade = rwsc_pkg::SPEED_OFF;
    end

    decision.vib_avg = vib_avg;
    decision.ir_avg  = ir_avg;
    if (grade == rwsc_pkg::SPEED_LOW && vib_avg >= levels.vib_moderate) begin
      decision.speed = rwsc_pkg::SPEED_MODERATE;
    end else if (grade == rwsc_pkg::SPEED_HIGH && vib_avg <= levels.vib_low) begin
      decision.speed = rwsc_pkg::SPEED_MODERATE;
    end else if (vib_avg <= levels.vib_off) begin
      decision.speed = rwsc_pkg::SPEED_OFF;
    end else begin
      decision.speed = grade;
    end
  end

endmodule
